// File: hw/rtl/timecode_frame_converter_top_macros.svh
// Assertion macros for the timecode frame converter.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TIMECODE_FRAME_CONVERTER_TOP_MACROS_SVH
`define TIMECODE_FRAME_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCFC_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcfc assertion failed");
`define TCFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcfc assertion failed");
`else
`define TCFC_ASSERT(label, clk, rst, ante, cons)
`define TCFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/tcfc_pkg.sv
// Shared types and constants for the timecode frame converter.
// No dependencies.
`default_nettype none

package tcfc_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_FPS       = 2'd0;
   localparam csr_index_type CSR_FPM       = 2'd1;
   localparam csr_index_type CSR_FPH       = 2'd2;
   localparam csr_index_type CSR_MAX_FRAME = 2'd3;

   localparam int CSR_DATA_W  = 19;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 80;

   localparam logic [6:0]  FPS_RESET       = 7'd25;
   localparam logic [12:0] FPM_RESET       = 13'd1500;
   localparam logic [18:0] FPH_RESET       = 19'd90000;
   localparam logic [6:0]  MAX_FRAME_RESET = 7'd24;

   localparam logic [19:0] HOURS_SAT = 20'd596523;
   localparam logic [7:0]  PART_SAT  = 8'd255;
   localparam logic [6:0]  FRAME_SAT = 7'd120;
   localparam logic [19:0] HOURS_MAX = 20'd23;
   localparam logic [7:0]  MIN_MAX   = 8'd59;
   localparam logic [7:0]  SEC_MAX   = 8'd59;

endpackage

`default_nettype wire

// File: hw/rtl/tcfc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; a zero divisor gives quotient 0 and the dividend as remainder.
`default_nettype none

module tcfc_div_pipe #(
   parameter int N  = 32,
   parameter int D  = 19,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [N-1:0]  in_dividend,
   input  logic [PW-1:0] in_side,
   input  logic [D-1:0]  divisor,
   output logic          out_valid,
   output logic [N-1:0]  out_quot,
   output logic [N-1:0]  out_rem,
   output logic [PW-1:0] out_side
);

   logic [N-1:0]  valid_ff;
   logic [N-1:0]  rem_ff  [N];
   logic [N-1:0]  dq_ff   [N];
   logic [PW-1:0] side_ff [N];
   logic [N-1:0]  rem_in  [N];
   logic [N-1:0]  dq_in   [N];
   logic [N:0]    div_ext;
   logic          div_zero;

   assign div_ext  = (N+1)'(divisor);
   assign div_zero = (divisor == '0);

   always_comb begin
      logic [N-1:0] rem_prev;
      logic [N-1:0] dq_prev;
      logic [N:0]   shifted;
      logic         take;
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            rem_prev = '0;
            dq_prev  = in_dividend;
         end else begin
            rem_prev = rem_ff[s-1];
            dq_prev  = dq_ff[s-1];
         end
         shifted   = {rem_prev, dq_prev[N-1]};
         take      = !div_zero && (shifted >= div_ext);
         rem_in[s] = take ? N'(shifted - div_ext) : shifted[N-1:0];
         dq_in[s]  = {dq_prev[N-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < N; s++) begin
            rem_ff[s]  <= rem_in[s];
            dq_ff[s]   <= dq_in[s];
            side_ff[s] <= (s == 0) ? in_side : side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quot  = dq_ff[N-1];
   assign out_rem   = rem_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

`default_nettype wire

// File: hw/rtl/timecode_frame_converter_top.sv
// Non-drop-frame timecode converter: splits a frame count into h:m:s:f.
// Depends on tcfc_pkg, tcfc_div_pipe and timecode_frame_converter_top_macros.svh.
//
// Use: an item on req_ carries a command in req_tuser. Command 0 splits the
// signed count req_tdata[31:0]; command 1 composes a count from the hour,
// minute, second and frame bytes with the frame-rate registers, then splits
// it. Every item gives exactly one item on rsp_: the count, hours, minutes,
// seconds and frames (all signed, truncating), with rsp_tuser set when they
// form a legal timecode. Counts saturate to COUNT_WIDTH bits (capped at 32).
// Registers are to be written on csr_ only while no item is in flight; the
// block does not enforce this. Throughput: one item per cycle while rsp_tready
// does not stall. An item passes four front stages, then three divider pipelines
// (hours, minutes, seconds) of W = min(COUNT_WIDTH, 32) stages each, a finish
// stage and an output register. Reset clears every valid bit and loads the
// 25 fps register defaults. While a result waits with rsp_tready low the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
`default_nettype none
`include "timecode_frame_converter_top_macros.svh"

module timecode_frame_converter_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // frame_count_in[31:0], hours_in, minutes_in, seconds_in, frames_in
   input  logic [tcfc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // frame_count_out[31:0], hours_out[20:0], minutes_out[8:0],
   // seconds_out[8:0], frames_out[7:0], one pad bit
   output logic [tcfc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // valid_res
   output logic                                rsp_tuser,
   input  logic                                csr_wr_en,
   input  tcfc_pkg::csr_index_type             csr_index,
   input  logic [tcfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import tcfc_pkg::*;

   localparam int WORK_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
   localparam logic [31:0] CNT_MAX = 32'h7FFF_FFFF >> (32 - WORK_W);
   localparam logic [31:0] CNT_MIN = ~CNT_MAX;
   localparam int SIDE1_W = WORK_W + 1;
   localparam int SIDE2_W = WORK_W + 21;
   localparam int SIDE3_W = WORK_W + 29;

   // config registers
   logic [6:0]  fps_ff;
   logic [12:0] fpm_ff;
   logic [18:0] fph_ff;
   logic [6:0]  max_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff       <= FPS_RESET;
         fpm_ff       <= FPM_RESET;
         fph_ff       <= FPH_RESET;
         max_frame_ff <= MAX_FRAME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FPS:       fps_ff       <= csr_wdata[6:0];
            CSR_FPM:       fpm_ff       <= csr_wdata[12:0];
            CSR_FPH:       fph_ff       <= csr_wdata;
            CSR_MAX_FRAME: max_frame_ff <= csr_wdata[6:0];
            default:       fps_ff       <= fps_ff;
         endcase
      end
   end

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // front stages: products, sum, select/saturate, sign/magnitude
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_cmd_ff, s2_cmd_ff;
   logic [31:0]       s1_cnt_ff, s2_cnt_ff;
   logic [26:0]       s1_hp_ff;
   logic [20:0]       s1_mp_ff;
   logic [14:0]       s1_sp_ff;
   logic [7:0]        s1_f_ff;
   logic [27:0]       s2_sum_ff;
   logic [WORK_W-1:0] s3_count_ff, s4_count_ff, s4_mag_ff;
   logic              s4_neg_ff;

   logic [26:0]       s1_hp_in;
   logic [20:0]       s1_mp_in;
   logic [14:0]       s1_sp_in;
   logic [27:0]       s2_sum_in;
   logic [31:0]       s3_sel;
   logic [31:0]       s3_comp;
   logic [WORK_W-1:0] s3_count_in, s4_mag_in;

   always_comb begin
      s1_hp_in  = 27'(req_tdata[39:32]) * 27'(fph_ff);
      s1_mp_in  = 21'(req_tdata[47:40]) * 21'(fpm_ff);
      s1_sp_in  = 15'(req_tdata[55:48]) * 15'(fps_ff);
      s2_sum_in = 28'(s1_hp_ff) + 28'(s1_mp_ff) + 28'(s1_sp_ff) + 28'(s1_f_ff);
      s3_comp   = 32'(s2_sum_ff);
      priority if (s2_cmd_ff) begin
         s3_sel = (s3_comp > CNT_MAX) ? CNT_MAX : s3_comp;
      end else if ($signed(s2_cnt_ff) > $signed(CNT_MAX)) begin
         s3_sel = CNT_MAX;
      end else if ($signed(s2_cnt_ff) < $signed(CNT_MIN)) begin
         s3_sel = CNT_MIN;
      end else begin
         s3_sel = s2_cnt_ff;
      end
      s3_count_in = WORK_W'(s3_sel);
      s4_mag_in   = s3_count_ff[WORK_W-1] ? (-s3_count_ff) : s3_count_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff   <= req_tuser;
         s1_cnt_ff   <= req_tdata[31:0];
         s1_hp_ff    <= s1_hp_in;
         s1_mp_ff    <= s1_mp_in;
         s1_sp_ff    <= s1_sp_in;
         s1_f_ff     <= req_tdata[63:56];
         s2_cmd_ff   <= s1_cmd_ff;
         s2_cnt_ff   <= s1_cnt_ff;
         s2_sum_ff   <= s2_sum_in;
         s3_count_ff <= s3_count_in;
         s4_count_ff <= s3_count_ff;
         s4_neg_ff   <= s3_count_ff[WORK_W-1];
         s4_mag_ff   <= s4_mag_in;
      end
   end

   // dividers: hours, minutes, seconds
   logic               d1_valid, d2_valid, d3_valid;
   logic [WORK_W-1:0]  d1_quot, d1_rem, d2_quot, d2_rem, d3_quot, d3_rem;
   logic [SIDE1_W-1:0] d1_side;
   logic [SIDE2_W-1:0] d2_side_in, d2_side;
   logic [SIDE3_W-1:0] d3_side_in, d3_side;
   logic [19:0]        hours_c;
   logic [7:0]         min_c;

   tcfc_div_pipe #(.N(WORK_W), .D(19), .PW(SIDE1_W)) u_div_hours (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s4_valid_ff),
      .in_dividend (s4_mag_ff),
      .in_side     ({s4_neg_ff, s4_count_ff}),
      .divisor     (fph_ff),
      .out_valid   (d1_valid),
      .out_quot    (d1_quot),
      .out_rem     (d1_rem),
      .out_side    (d1_side)
   );

   always_comb begin
      hours_c    = (d1_quot > WORK_W'(HOURS_SAT)) ? HOURS_SAT : d1_quot[19:0];
      d2_side_in = {hours_c, d1_side};
      min_c      = (d2_quot > WORK_W'(PART_SAT)) ? PART_SAT : d2_quot[7:0];
      d3_side_in = {min_c, d2_side};
   end

   tcfc_div_pipe #(.N(WORK_W), .D(13), .PW(SIDE2_W)) u_div_minutes (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (d1_valid),
      .in_dividend (d1_rem),
      .in_side     (d2_side_in),
      .divisor     (fpm_ff),
      .out_valid   (d2_valid),
      .out_quot    (d2_quot),
      .out_rem     (d2_rem),
      .out_side    (d2_side)
   );

   tcfc_div_pipe #(.N(WORK_W), .D(7), .PW(SIDE3_W)) u_div_seconds (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (d2_valid),
      .in_dividend (d2_rem),
      .in_side     (d3_side_in),
      .divisor     (fps_ff),
      .out_valid   (d3_valid),
      .out_quot    (d3_quot),
      .out_rem     (d3_rem),
      .out_side    (d3_side)
   );

   // finish stage: saturate, range check
   logic                     f1_valid_ff, f1_neg_ff, f1_ok_ff;
   logic signed [WORK_W-1:0] f1_count_ff;
   logic [19:0]              f1_hours_ff;
   logic [7:0]               f1_min_ff, f1_sec_ff;
   logic [6:0]               f1_frm_ff;
   logic [7:0]               sec_c;
   logic [6:0]               frm_c;
   logic                     d3_neg;
   logic [19:0]              d3_hours;
   logic [7:0]               d3_min;
   logic                     f1_ok_in;

   always_comb begin
      d3_neg   = d3_side[WORK_W];
      d3_hours = d3_side[WORK_W+20:WORK_W+1];
      d3_min   = d3_side[WORK_W+28:WORK_W+21];
      sec_c    = (d3_quot > WORK_W'(PART_SAT)) ? PART_SAT : d3_quot[7:0];
      frm_c    = (d3_rem > WORK_W'(FRAME_SAT)) ? FRAME_SAT : d3_rem[6:0];
      f1_ok_in = !d3_neg && (d3_hours <= HOURS_MAX) && (d3_min <= MIN_MAX)
               && (sec_c <= SEC_MAX) && (frm_c <= max_frame_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_neg_ff   <= d3_neg;
         f1_count_ff <= d3_side[WORK_W-1:0];
         f1_hours_ff <= d3_hours;
         f1_min_ff   <= d3_min;
         f1_sec_ff   <= sec_c;
         f1_frm_ff   <= frm_c;
         f1_ok_ff    <= f1_ok_in;
      end
   end

   // output register: apply sign
   logic               out_valid_ff, out_ok_ff;
   logic signed [31:0] out_count_ff;
   logic signed [20:0] out_hours_ff;
   logic signed [8:0]  out_min_ff, out_sec_ff;
   logic signed [7:0]  out_frm_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_count_ff <= 32'(f1_count_ff);
         out_hours_ff <= f1_neg_ff ? -21'(f1_hours_ff) : 21'(f1_hours_ff);
         out_min_ff   <= f1_neg_ff ? -9'(f1_min_ff) : 9'(f1_min_ff);
         out_sec_ff   <= f1_neg_ff ? -9'(f1_sec_ff) : 9'(f1_sec_ff);
         out_frm_ff   <= f1_neg_ff ? -8'(f1_frm_ff) : 8'(f1_frm_ff);
         out_ok_ff    <= f1_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         f1_valid_ff  <= d3_valid;
         out_valid_ff <= f1_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {1'b0, out_frm_ff, out_sec_ff, out_min_ff, out_hours_ff, out_count_ff};

   `TCFC_ASSERT(a_legal_when_flagged, clock, reset, rsp_tvalid && rsp_tuser,
      !out_hours_ff[20] && (out_hours_ff <= 21'sd23) && !out_min_ff[8]
      && (out_min_ff <= 9'sd59) && !out_sec_ff[8] && (out_sec_ff <= 9'sd59)
      && !out_frm_ff[7] && (out_frm_ff[6:0] <= max_frame_ff))
   `TCFC_ASSERT(a_negative_not_legal, clock, reset, rsp_tvalid && out_count_ff[31], !rsp_tuser)
   `TCFC_ASSERT(a_zero_count_parts, clock, reset, rsp_tvalid && (out_count_ff == '0),
      rsp_tuser && (out_hours_ff == '0) && (out_min_ff == '0) && (out_sec_ff == '0)
      && (out_frm_ff == '0))
   `TCFC_ASSERT(a_frame_rem_below_rate, clock, reset, d3_valid && (fps_ff != '0),
      d3_rem < WORK_W'(fps_ff))

endmodule

`default_nettype wire
